/* hdl/ccsb_pkg.sv */
// ----------------------------------------------------------------------------
// ccsb_pkg: shared definitions for the color-key sprite blit core
// Widths, register indexes, the configuration record and the stage record.
// ----------------------------------------------------------------------------
package ccsb_pkg;

  localparam int unsigned PIXEL_W   = 32;
  localparam int unsigned ADDR_W    = 21;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned SPAN_W    = 12;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned POS_W     = COORD_W + 1;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned PROD_W    = 2 * SPAN_W;

  // Framebuffer row pitch in pixels.
  localparam int unsigned FB_STRIDE = 1024;
  // Largest rectangle edge; anything wider acts as this.
  localparam logic [SPAN_W-1:0] MAX_SPAN = SPAN_W'(2048);
  localparam logic [SPAN_W-1:0] CLIP_RESET = SPAN_W'(1024);
  localparam logic [PIXEL_W-1:0] COLOR_KEY = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_X      = 4'd0,
    REG_DEST_Y      = 4'd1,
    REG_RECT_WIDTH  = 4'd2,
    REG_RECT_HEIGHT = 4'd3,
    REG_WIN_LEFT    = 4'd4,
    REG_WIN_TOP     = 4'd5,
    REG_WIN_RIGHT   = 4'd6,
    REG_WIN_BOTTOM  = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] dest_x;
    logic signed [COORD_W-1:0] dest_y;
    logic [SPAN_W-1:0]         rect_width;
    logic [SPAN_W-1:0]         rect_height;
    logic [SPAN_W-1:0]         win_left;
    logic [SPAN_W-1:0]         win_top;
    logic [SPAN_W-1:0]         win_right;
    logic [SPAN_W-1:0]         win_bottom;
  } cfg_t;

  // Contents of the input register: one pixel with its destination.
  typedef struct packed {
    logic                    valid;
    logic [PIXEL_W-1:0]      pixel;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } stage_t;

endpackage

/* hdl/ccsb_src_if.sv */
// ----------------------------------------------------------------------------
// ccsb_src_if: source pixel stream
// Valid/ready channel carrying one fetched sprite pixel per transfer.
// ----------------------------------------------------------------------------
interface ccsb_src_if;
  logic        valid;
  logic        ready;
  logic [31:0] src_pixel;

  modport source (output valid, output src_pixel, input ready);
  modport sink (input valid, input src_pixel, output ready);
endinterface

/* hdl/ccsb_wr_if.sv */
// ----------------------------------------------------------------------------
// ccsb_wr_if: framebuffer write stream
// Valid/ready channel carrying one framebuffer write per transfer.
// ----------------------------------------------------------------------------
interface ccsb_wr_if;
  logic        valid;
  logic        ready;
  logic [20:0] write_address;
  logic [31:0] write_pixel;

  modport source (output valid, output write_address, output write_pixel, input ready);
  modport sink (input valid, input write_address, input write_pixel, output ready);
endinterface

/* hdl/ccsb_cfg.sv */
// ----------------------------------------------------------------------------
// ccsb_cfg: configuration register file
// Holds the placement, rectangle size and clip window; flags every write to a valid index.
// ----------------------------------------------------------------------------
module ccsb_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ccsb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ccsb_pkg::CFG_DAT_W-1:0]     cfg_wdata_i,
  output ccsb_pkg::cfg_t                     cfg_o,
  output logic                               clear_o
);
  import ccsb_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic             hit;
  logic [SPAN_W-1:0] v12;

  assign v12 = cfg_wdata_i[SPAN_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    hit   = 1'b0;
    if (cfg_we_i) begin
      hit = 1'b1;
      case (cfg_reg_e'(cfg_index_i))
        REG_DEST_X:      cfg_d.dest_x      = $signed(cfg_wdata_i);
        REG_DEST_Y:      cfg_d.dest_y      = $signed(cfg_wdata_i);
        REG_RECT_WIDTH:  cfg_d.rect_width  = v12;
        REG_RECT_HEIGHT: cfg_d.rect_height = v12;
        REG_WIN_LEFT:    cfg_d.win_left    = v12;
        REG_WIN_TOP:     cfg_d.win_top     = v12;
        REG_WIN_RIGHT:   cfg_d.win_right   = v12;
        REG_WIN_BOTTOM:  cfg_d.win_bottom  = v12;
        default:         hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_x      <= '0;
      cfg_q.dest_y      <= '0;
      cfg_q.rect_width  <= '0;
      cfg_q.rect_height <= '0;
      cfg_q.win_left    <= '0;
      cfg_q.win_top     <= '0;
      cfg_q.win_right   <= CLIP_RESET;
      cfg_q.win_bottom  <= CLIP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o   = cfg_q;
  assign clear_o = hit;

endmodule

/* hdl/ccsb_pos.sv */
// ----------------------------------------------------------------------------
// ccsb_pos: raster position tracking and input register
// Steps the column and row counters and registers each pixel with its
// destination coordinates.
// ----------------------------------------------------------------------------
module ccsb_pos (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ccsb_pkg::cfg_t                  cfg_i,
  input  logic                            clear_i,
  input  logic                            accept_i,
  input  logic [ccsb_pkg::PIXEL_W-1:0]    pixel_i,
  input  logic                            take_i,
  output ccsb_pkg::stage_t                stage_o
);
  import ccsb_pkg::*;

  logic [COUNT_W-1:0] col_q, col_d, row_q, row_d;
  logic [SPAN_W-1:0]  w, h, col_inc, row_inc;
  logic               active;
  logic               valid_q, valid_d;
  logic [PIXEL_W-1:0] pixel_q;
  logic signed [POS_W-1:0] x_q, y_q;

  // Oversized spans are clamped.
  assign w      = (cfg_i.rect_width  > MAX_SPAN) ? MAX_SPAN : cfg_i.rect_width;
  assign h      = (cfg_i.rect_height > MAX_SPAN) ? MAX_SPAN : cfg_i.rect_height;
  assign active = (w != '0) && (h != '0);

  assign col_inc = {1'b0, col_q} + SPAN_W'(1);
  assign row_inc = {1'b0, row_q} + SPAN_W'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (clear_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept_i && active) begin
      if (col_inc >= w) begin
        col_d = '0;
        row_d = (row_inc >= h) ? '0 : row_inc[COUNT_W-1:0];
      end else begin
        col_d = col_inc[COUNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (accept_i && active) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      valid_q <= valid_d;
    end
  end

  // Payload: destination is the signed placement plus the counters.
  always_ff @(posedge clk_i) begin
    if (accept_i && active) begin
      pixel_q <= pixel_i;
      x_q     <= POS_W'(cfg_i.dest_x) + $signed({{(POS_W-COUNT_W){1'b0}}, col_q});
      y_q     <= POS_W'(cfg_i.dest_y) + $signed({{(POS_W-COUNT_W){1'b0}}, row_q});
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.pixel = pixel_q;
  assign stage_o.x     = x_q;
  assign stage_o.y     = y_q;

endmodule

/* hdl/ccsb_clip.sv */
// ----------------------------------------------------------------------------
// ccsb_clip: clip test, color key and address generation
// Decides whether a registered pixel is drawn and loads the result register.
// ----------------------------------------------------------------------------
module ccsb_clip (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ccsb_pkg::cfg_t                  cfg_i,
  input  ccsb_pkg::stage_t                stage_i,
  input  logic                            out_ready_i,
  output logic                            take_o,
  output logic                            out_valid_o,
  output logic [ccsb_pkg::ADDR_W-1:0]     out_address_o,
  output logic [ccsb_pkg::PIXEL_W-1:0]    out_pixel_o
);
  import ccsb_pkg::*;

  logic               draw, in_x, in_y, load;
  logic               valid_q, valid_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [PIXEL_W-1:0] pixel_q;
  logic [PROD_W-1:0]  row_base;

  assign in_x = (stage_i.x >= $signed({{(POS_W-SPAN_W){1'b0}}, cfg_i.win_left}))
             && (stage_i.x <  $signed({{(POS_W-SPAN_W){1'b0}}, cfg_i.win_right}));
  assign in_y = (stage_i.y >= $signed({{(POS_W-SPAN_W){1'b0}}, cfg_i.win_top}))
             && (stage_i.y <  $signed({{(POS_W-SPAN_W){1'b0}}, cfg_i.win_bottom}));
  assign draw = stage_i.valid && (stage_i.pixel != COLOR_KEY) && in_x && in_y;

  // A drawn pixel lies inside the window, so both coordinates fit in SPAN_W bits.
  assign row_base = PROD_W'(stage_i.y[SPAN_W-1:0]) * PROD_W'(FB_STRIDE);
  assign addr_d   = row_base[ADDR_W-1:0] + ADDR_W'(stage_i.x[SPAN_W-1:0]);

  assign load    = !valid_q || out_ready_i;
  assign take_o  = stage_i.valid && (!draw || load);
  assign valid_d = load ? draw : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && draw) begin
      addr_q  <= addr_d;
      pixel_q <= stage_i.pixel;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_address_o = addr_q;
  assign out_pixel_o   = pixel_q;

endmodule

/* hdl/clipped_colorkey_sprite_blit_core.sv */
// ----------------------------------------------------------------------------
// clipped_colorkey_sprite_blit_core: color-key sprite blit with clipping
// Turns a raster stream of sprite pixels into framebuffer writes, dropping
// transparent pixels and pixels outside the viewport window.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Handshake     Payload
//   --------  ---  ------------  ------------------------------------------
//   src_i     in   valid/ready   src_pixel (32 bit ARGB, zero = transparent)
//   wr_o      out  valid/ready   write_address (21 bit), write_pixel (32 bit)
//   cfg       in   cfg_we_i      cfg_index_i (4 bit), cfg_wdata_i (16 bit)
//
// One pixel is taken per cycle unless a stalled wr_o holds a drawn pixel
// back. The destination add happens on the way into the input register at
// the edge of the source transfer; the window compare and stride multiply
// then load the result register, which drives wr_o, once that register is
// empty or its write leaves.
// Reset is asynchronous and active low; src_i.ready stays low for the first
// cycle after reset is released.
// A stalled wr_o holds its write; the input register keeps taking pixels as
// long as its content can move on, and a clipped or transparent pixel never
// waits for wr_o.
// ----------------------------------------------------------------------------
module clipped_colorkey_sprite_blit_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ccsb_src_if.sink                      src_i,
  ccsb_wr_if.source                     wr_o,
  input  logic                          cfg_we_i,
  input  logic [ccsb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ccsb_pkg::CFG_DAT_W-1:0] cfg_wdata_i
);
  import ccsb_pkg::*;

  cfg_t   cfg;
  stage_t stage;
  logic   clear;
  logic   take;
  logic   accept;
  logic   run_q;

  // Holds ready low for one cycle after reset so that no transfer is counted
  // while the registers are still being released.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= 1'b1;
    end
  end

  // The input register takes a pixel when it is empty or its pixel leaves now.
  assign src_i.ready = run_q && (!stage.valid || take);
  assign accept      = src_i.valid && src_i.ready;

  // Register file; any valid write restarts the rectangle at its first pixel.
  ccsb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .clear_o     (clear)
  );

  // Column/row counters and the input register. With an empty rectangle the
  // pixel is taken and dropped, and the counters do not move.
  ccsb_pos u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .clear_i  (clear),
    .accept_i (accept),
    .pixel_i  (src_i.src_pixel),
    .take_i   (take),
    .stage_o  (stage)
  );

  // Window test, color key, address and the result register.
  ccsb_clip u_clip (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .stage_i       (stage),
    .out_ready_i   (wr_o.ready),
    .take_o        (take),
    .out_valid_o   (wr_o.valid),
    .out_address_o (wr_o.write_address),
    .out_pixel_o   (wr_o.write_pixel)
  );

endmodule

/* hdl/ccsb_checker.sv */
// ----------------------------------------------------------------------------
// ccsb_checker: port-level assertions for the sprite blit core
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module ccsb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        src_valid_i,
  input logic        src_ready_i,
  input logic        wr_valid_i,
  input logic        wr_ready_i,
  input logic [20:0] wr_address_i,
  input logic [31:0] wr_pixel_i
);

  logic src_xfer;
  assign src_xfer = src_valid_i && src_ready_i;

  // A stalled write stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_i && !wr_ready_i |=> wr_valid_i)
    else $error("write withdrawn while stalled");

  // A stalled write keeps its address and pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_i && !wr_ready_i |=> $stable(wr_address_i) && $stable(wr_pixel_i))
    else $error("write payload changed while stalled");

  // The transparent color is never written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_valid_i |-> wr_pixel_i != 32'd0)
    else $error("transparent pixel written");

  // A write appearing on an idle output comes from a source transfer whose
  // pixel went straight on from the input register into the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(wr_valid_i) |-> $past(src_xfer, 2))
    else $error("write without a matching source transfer");

endmodule

bind clipped_colorkey_sprite_blit_core ccsb_checker u_ccsb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .src_valid_i  (src_i.valid),
  .src_ready_i  (src_i.ready),
  .wr_valid_i   (wr_o.valid),
  .wr_ready_i   (wr_o.ready),
  .wr_address_i (wr_o.write_address),
  .wr_pixel_i   (wr_o.write_pixel)
);

/* bench/clipped_colorkey_sprite_blit_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clipped_colorkey_sprite_blit_core_tb: self-checking bench for the blit core
// Streams sprite pixels into the core under random source gaps and sink
// stalls. A behavioral predictor tracks the raster position and the register
// file and queues every framebuffer write the core should produce. Each write
// the core hands over is checked field by field against that queue.
// ----------------------------------------------------------------------------
module clipped_colorkey_sprite_blit_core_tb;
  import ccsb_pkg::*;

  // The longest random wait either side takes before a transfer.
  localparam int MAX_IDLE = 12;
  // A clipped pixel leaves no write behind, so after the queue drains the
  // bench still idles for a margin before it touches the registers or ends
  // the run.
  localparam int IDLE_SLACK = 4;
  localparam int CYCLE_LIMIT = 250000;
  localparam int RANDOM_PIXELS = 650;
  localparam int NUM_REGS = 8;

  // One framebuffer write as the core should present it.
  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [PIXEL_W-1:0] pixel;
  } fb_write_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_wdata_i;

  ccsb_src_if src_if ();
  ccsb_wr_if  wr_if ();

  clipped_colorkey_sprite_blit_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_i       (src_if),
    .wr_o        (wr_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predictor state: the register file as the core should hold it, plus the
  // position of the next pixel inside the source rectangle.
  cfg_t blit_cfg;
  logic [COUNT_W-1:0] col_pos;
  logic [COUNT_W-1:0] row_pos;

  // Writes that the core still owes, oldest first.
  fb_write_t pending_writes[$];

  bit src_gaps_on;
  bit sink_stalls_on;
  int unsigned mismatches;
  int unsigned writes_checked;
  int unsigned pixels_used;
  int unsigned settings_used;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Rectangle edges beyond the largest span behave as the largest span.
  function automatic int clamp_span(input logic [SPAN_W-1:0] span);
    return (span > MAX_SPAN) ? int'(MAX_SPAN) : int'(span);
  endfunction

  function automatic void reset_blit_state();
    blit_cfg = '0;
    blit_cfg.win_right = CLIP_RESET;
    blit_cfg.win_bottom = CLIP_RESET;
    col_pos = '0;
    row_pos = '0;
  endfunction

  // Mirrors one register write. Indexes past the register file change
  // nothing, not even the raster position; every real write rewinds the
  // rectangle to its first pixel.
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DAT_W-1:0] data);
    case (idx)
      REG_DEST_X:      blit_cfg.dest_x = data;
      REG_DEST_Y:      blit_cfg.dest_y = data;
      REG_RECT_WIDTH:  blit_cfg.rect_width = data[SPAN_W-1:0];
      REG_RECT_HEIGHT: blit_cfg.rect_height = data[SPAN_W-1:0];
      REG_WIN_LEFT:    blit_cfg.win_left = data[SPAN_W-1:0];
      REG_WIN_TOP:     blit_cfg.win_top = data[SPAN_W-1:0];
      REG_WIN_RIGHT:   blit_cfg.win_right = data[SPAN_W-1:0];
      REG_WIN_BOTTOM:  blit_cfg.win_bottom = data[SPAN_W-1:0];
      default:         return;
    endcase
    col_pos = '0;
    row_pos = '0;
  endfunction

  // Works out what one accepted pixel should do and queues the write it
  // causes, if any. Returns whether the pixel belonged to a rectangle at all;
  // with a zero width or height the core ignores it and nothing moves.
  function automatic bit predict_write(input logic [PIXEL_W-1:0] pixel);
    int span_w;
    int span_h;
    int x;
    int y;
    bit draw;
    fb_write_t fb;
    span_w = clamp_span(blit_cfg.rect_width);
    span_h = clamp_span(blit_cfg.rect_height);
    if (span_w == 0 || span_h == 0) begin
      return 1'b0;
    end
    x = int'($signed(blit_cfg.dest_x)) + int'(col_pos);
    y = int'($signed(blit_cfg.dest_y)) + int'(row_pos);
    // The window is half open on both axes, and the key color never draws.
    draw = (pixel != COLOR_KEY)
        && x >= int'(blit_cfg.win_left) && x < int'(blit_cfg.win_right)
        && y >= int'(blit_cfg.win_top) && y < int'(blit_cfg.win_bottom);
    // Raster walk: wrap the column at the row end, and wrap both counters
    // after the last pixel so the next rectangle starts clean.
    if (int'(col_pos) + 1 >= span_w) begin
      col_pos = '0;
      row_pos = (int'(row_pos) + 1 >= span_h) ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    if (draw) begin
      // Columns past the stride simply spill into the next framebuffer row,
      // and the address wraps at its own width.
      fb.address = ADDR_W'(y * FB_STRIDE + x);
      fb.pixel = pixel;
      pending_writes.push_back(fb);
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Source side and register port
  // --------------------------------------------------------------------------

  // Drives one pixel and waits for its transfer. The valid stays high after
  // the transfer so that a back-to-back pixel needs no second assignment in
  // the same time step; a gap lowers it and scrambles the data meanwhile.
  task automatic send_pixel(input logic [PIXEL_W-1:0] pixel);
    int gap;
    gap = src_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      src_if.valid <= 1'b0;
      src_if.src_pixel <= $urandom();
      repeat (gap) @(posedge clk_i);
    end
    src_if.valid <= 1'b1;
    src_if.src_pixel <= pixel;
    do @(posedge clk_i); while (!src_if.ready);
    if (predict_write(pixel)) begin
      pixels_used++;
    end
  endtask

  // Stops the source and waits until the core has delivered every write it
  // owes, then a little longer for a clipped pixel that may still be inside.
  task automatic wait_until_idle();
    src_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (IDLE_SLACK) @(posedge clk_i);
  endtask

  // A single register write; the enable is dropped again before the task returns.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [PIXEL_W-1:0] random_pixel();
    return ($urandom_range(0, 3) == 0) ? COLOR_KEY : PIXEL_W'($urandom());
  endfunction

  // --------------------------------------------------------------------------
  // Sink side: draws a stall after every transfer, and now and then drops
  // ready while nothing is offered, so stalls land on every pipeline phase.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    stall = 0;
    wr_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (wr_if.valid && wr_if.ready) begin
        stall = sink_stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
        wr_if.ready <= (stall == 0);
      end else if (!wr_if.ready) begin
        if (stall <= 1) begin
          wr_if.ready <= 1'b1;
        end
        stall--;
      end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, MAX_IDLE);
        wr_if.ready <= 1'b0;
      end
    end
  end

  // Every write transfer is matched against the oldest queued expectation.
  always @(posedge clk_i) begin
    fb_write_t want;
    if (rst_ni && wr_if.valid && wr_if.ready) begin
      if (pending_writes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected write: expected none, actual address %h pixel %h",
                 $time, wr_if.write_address, wr_if.write_pixel);
      end else begin
        want = pending_writes.pop_front();
        writes_checked++;
        if (wr_if.write_address !== want.address) begin
          mismatches++;
          $display("%0t: write_address mismatch: expected %h, actual %h",
                   $time, want.address, wr_if.write_address);
        end
        if (wr_if.write_pixel !== want.pixel) begin
          mismatches++;
          $display("%0t: write_pixel mismatch: expected %h, actual %h",
                   $time, want.pixel, wr_if.write_pixel);
        end
      end
    end
  end

  // Watchdog: a hung handshake or a missing write ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: no progress after %0d cycles", $time, cycle_count);
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Out of reset the rectangle is empty, so pixels pass without effect. A
  // width alone is still an empty rectangle.
  task automatic test_empty_rect();
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h0000_0001);
    wait_until_idle();
    write_reg(REG_RECT_WIDTH, 16'd3);
    send_pixel(32'hDEAD_BEEF);
    settings_used++;
  endtask

  // A 3 by 2 rectangle inside the reset window: raster order, the key color,
  // extreme pixel values, and the wrap back to the first pixel at the end.
  task automatic test_raster_walk();
    wait_until_idle();
    write_reg(REG_DEST_X, 16'd5);
    write_reg(REG_DEST_Y, 16'd7);
    write_reg(REG_RECT_HEIGHT, 16'd2);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(COLOR_KEY);
    send_pixel(32'h8000_0000);
    send_pixel(32'h0000_0001);
    send_pixel(32'h5555_5555);
    send_pixel(32'hAAAA_AAAA);
    send_pixel(32'h1234_5678);
    settings_used++;
  endtask

  // One-column window with a one-row window under it, and the rectangle
  // hanging off the left: left and top bounds are inclusive, right and bottom
  // bounds exclusive, and negative destinations never draw.
  task automatic test_window_edges();
    int i;
    wait_until_idle();
    write_reg(REG_DEST_X, 16'hFFFF);
    write_reg(REG_DEST_Y, 16'd0);
    write_reg(REG_RECT_WIDTH, 16'd4);
    write_reg(REG_RECT_HEIGHT, 16'd2);
    write_reg(REG_WIN_LEFT, 16'd1);
    write_reg(REG_WIN_RIGHT, 16'd2);
    write_reg(REG_WIN_TOP, 16'd0);
    write_reg(REG_WIN_BOTTOM, 16'd1);
    for (i = 0; i < 8; i++) begin
      send_pixel(PIXEL_W'($urandom()) | 32'h1);
    end
    settings_used++;
  endtask

  // An inverted column window and an empty row window both draw nothing.
  task automatic test_empty_window();
    wait_until_idle();
    write_reg(REG_WIN_LEFT, 16'd5);
    write_reg(REG_WIN_RIGHT, 16'd3);
    send_pixel(32'hCAFE_F00D);
    wait_until_idle();
    write_reg(REG_WIN_LEFT, 16'd0);
    write_reg(REG_WIN_RIGHT, 16'(MAX_SPAN));
    write_reg(REG_WIN_TOP, 16'd9);
    write_reg(REG_WIN_BOTTOM, 16'd9);
    send_pixel(32'h0BAD_F00D);
    settings_used += 2;
  endtask

  // Bottom-right corner of the address space: the second column crosses the
  // stride and the address wraps to zero. Then the most positive and the
  // most negative placements, which fall far outside any window.
  task automatic test_address_wrap();
    wait_until_idle();
    write_reg(REG_WIN_TOP, 16'd0);
    write_reg(REG_WIN_RIGHT, 16'hFFFF);
    write_reg(REG_WIN_BOTTOM, 16'hFFFF);
    write_reg(REG_DEST_X, 16'd1023);
    write_reg(REG_DEST_Y, 16'd2047);
    write_reg(REG_RECT_WIDTH, 16'd2);
    write_reg(REG_RECT_HEIGHT, 16'd1);
    send_pixel(32'h7FFF_FFFF);
    send_pixel(32'hFFFF_FFFE);
    wait_until_idle();
    write_reg(REG_DEST_X, 16'h7FFF);
    write_reg(REG_DEST_Y, 16'h7FFF);
    send_pixel(32'h0F0F_0F0F);
    wait_until_idle();
    write_reg(REG_DEST_X, 16'h8000);
    write_reg(REG_DEST_Y, 16'h8000);
    send_pixel(32'hF0F0_F0F0);
    settings_used += 3;
  endtask

  // Random window corner: mostly near the origin, sometimes at the extremes.
  function automatic logic [SPAN_W-1:0] pick_bound();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return MAX_SPAN;
      2:       return '1;
      default: return SPAN_W'($urandom_range(0, 40));
    endcase
  endfunction

  // Random rectangle edge: mostly small, sometimes empty or oversized.
  function automatic logic [SPAN_W-1:0] pick_span();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return MAX_SPAN;
      2:       return '1;
      3:       return MAX_SPAN + 1'b1;
      default: return SPAN_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Random placement: mostly straddling the given window edge so that both
  // clipped and drawn pixels come up, sometimes at the 16-bit extremes.
  function automatic logic [COORD_W-1:0] pick_origin(input logic [SPAN_W-1:0] edge_pos);
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return COORD_W'($urandom());
      default: return COORD_W'(int'(edge_pos) + int'($urandom_range(0, 16)) - 8);
    endcase
  endfunction

  // Random sprites: each pass picks a new window, placement and size, writes
  // some or all of the registers in random order, then streams a rectangle or
  // two of pixels. Some passes only poke an index outside the register file,
  // so the previous rectangle carries on where it left off.
  task automatic test_random_sprites();
    cfg_t next;
    cfg_reg_e order [NUM_REGS];
    cfg_reg_e swap_reg;
    logic [CFG_DAT_W-1:0] data;
    logic [3:0] junk;
    int start;
    int pass;
    int mode;
    int count;
    int area;
    int pause_at;
    int i;
    int k;
    start = pixels_used;
    pass = 0;
    while (pixels_used - start < RANDOM_PIXELS) begin
      wait_until_idle();
      src_gaps_on = ($urandom_range(0, 3) != 0);
      sink_stalls_on = ($urandom_range(0, 3) != 0);

      next.win_left = pick_bound();
      next.win_top = pick_bound();
      next.win_right = ($urandom_range(0, 7) != 0)
          ? next.win_left + SPAN_W'($urandom_range(0, 24)) : pick_bound();
      next.win_bottom = ($urandom_range(0, 7) != 0)
          ? next.win_top + SPAN_W'($urandom_range(0, 24)) : pick_bound();
      next.dest_x = pick_origin(next.win_left);
      next.dest_y = pick_origin(next.win_top);
      next.rect_width = pick_span();
      next.rect_height = pick_span();

      for (i = 0; i < NUM_REGS; i++) begin
        order[i] = cfg_reg_e'(i);
      end
      for (i = NUM_REGS - 1; i > 0; i--) begin
        k = $urandom_range(0, i);
        swap_reg = order[i];
        order[i] = order[k];
        order[k] = swap_reg;
      end

      mode = $urandom_range(0, 7);
      if (pass != 0 && mode == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 2 ** CFG_IDX_W - 1)),
                  CFG_DAT_W'($urandom()));
      end else begin
        // Two registers only, or the whole file.
        for (i = 0; i < ((pass != 0 && mode == 1) ? 2 : NUM_REGS); i++) begin
          // The upper data bits of the 12-bit registers must be ignored.
          junk = 4'($urandom());
          case (order[i])
            REG_DEST_X:      data = next.dest_x;
            REG_DEST_Y:      data = next.dest_y;
            REG_RECT_WIDTH:  data = {junk, next.rect_width};
            REG_RECT_HEIGHT: data = {junk, next.rect_height};
            REG_WIN_LEFT:    data = {junk, next.win_left};
            REG_WIN_TOP:     data = {junk, next.win_top};
            REG_WIN_RIGHT:   data = {junk, next.win_right};
            default:         data = {junk, next.win_bottom};
          endcase
          write_reg(order[i], data);
        end
      end
      settings_used++;

      area = clamp_span(blit_cfg.rect_width) * clamp_span(blit_cfg.rect_height);
      if (area == 0) begin
        count = 3;
      end else begin
        count = area * $urandom_range(1, 2) + $urandom_range(0, 3);
        if (count > 80) begin
          count = 80;
        end
      end

      // Now and then the source holds off mid-rectangle until every write
      // it has caused so far has been delivered.
      pause_at = (pass == 0 || $urandom_range(0, 4) == 0) ? count / 2 : -1;
      for (i = 0; i < count; i++) begin
        if (i == pause_at) begin
          wait_until_idle();
        end
        send_pixel(random_pixel());
      end
      pass++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int directed_pixels;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_wdata_i <= '0;
    src_if.valid <= 1'b0;
    src_if.src_pixel <= '0;
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    mismatches = 0;
    writes_checked = 0;
    pixels_used = 0;
    settings_used = 0;
    reset_blit_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_rect();
    test_raster_walk();
    test_window_edges();
    test_empty_window();
    test_address_wrap();
    directed_pixels = pixels_used;
    test_random_sprites();
    wait_until_idle();

    $display("Streamed %0d in-rectangle pixels (%0d in directed cases) over %0d settings.",
             pixels_used, directed_pixels, settings_used);
    $display("Checked %0d framebuffer writes, %0d mismatches.", writes_checked, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ccsb_pkg.sv
hdl/ccsb_src_if.sv
hdl/ccsb_wr_if.sv
hdl/ccsb_cfg.sv
hdl/ccsb_pos.sv
hdl/ccsb_clip.sv
hdl/clipped_colorkey_sprite_blit_core.sv
hdl/ccsb_checker.sv
bench/clipped_colorkey_sprite_blit_core_tb.sv
